@@ hdl/rau_pkg.sv @@
// rau_pkg: widths, action/status/order codes and shared types of the rational arithmetic unit
// used by rau_div and rational_arithmetic_unit_core; depends on nothing
package rau_pkg;

  // operand width inside the datapath and widths of the fixed port fields
  localparam int VALUE_WIDTH = 32;
  localparam int FIELD_W     = 32;
  localparam int DEN_W       = 31;
  localparam int PROD_W      = 2 * VALUE_WIDTH;
  localparam int DIV_CNT_W   = $clog2(VALUE_WIDTH + 1);

  // action codes
  localparam logic [2:0] ACT_ADD = 3'd0;
  localparam logic [2:0] ACT_SUB = 3'd1;
  localparam logic [2:0] ACT_MUL = 3'd2;
  localparam logic [2:0] ACT_DIV = 3'd3;
  localparam logic [2:0] ACT_RED = 3'd4;
  localparam logic [2:0] ACT_CMP = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  // compare outcomes
  localparam logic [1:0] ORD_EQ   = 2'd0;
  localparam logic [1:0] ORD_LESS = 2'd1;
  localparam logic [1:0] ORD_GRTR = 2'd2;

  // 2^(VALUE_WIDTH-1) at product width, the edge of the signed result range
  localparam logic [PROD_W-1:0] HALF =
    {{VALUE_WIDTH{1'b0}}, 1'b1, {(VALUE_WIDTH-1){1'b0}}};

  // request and response of the shared divider
  typedef struct packed {
    logic                   go;
    logic [VALUE_WIDTH-1:0] dividend;
    logic [VALUE_WIDTH-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic [VALUE_WIDTH-1:0] quo;
    logic [VALUE_WIDTH-1:0] rem;
  } div_rsp_t;

  // magnitude of a two's complement value; the most negative value maps to 2^(w-1)
  function automatic logic [VALUE_WIDTH-1:0] mag_of(input logic [VALUE_WIDTH-1:0] v);
    mag_of = v[VALUE_WIDTH-1] ? (~v + VALUE_WIDTH'(1)) : v;
  endfunction

endpackage

@@ hdl/rau_div.sv @@
// rau_div: restoring unsigned divider, one quotient bit per cycle
// depends on rau_pkg (widths, div_req_t, div_rsp_t)
module rau_div import rau_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [VALUE_WIDTH-1:0] quo_r, quo_nxt;
  logic [VALUE_WIDTH-1:0] rem_r, rem_nxt;
  logic [VALUE_WIDTH-1:0] dsr_r, dsr_nxt;
  logic [DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                   done_r, done_nxt;
  logic [VALUE_WIDTH:0]   shifted;
  logic [VALUE_WIDTH:0]   trial;

  // one shift and trial subtract per cycle
  always_comb begin
    shifted  = {rem_r, quo_r[VALUE_WIDTH-1]};
    trial    = shifted - {1'b0, dsr_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (req.go) begin
      quo_nxt = req.dividend;
      rem_nxt = '0;
      dsr_nxt = req.divisor;
      cnt_nxt = DIV_CNT_W'(VALUE_WIDTH);
    end else if (cnt_r != '0) begin
      if (!trial[VALUE_WIDTH]) begin
        rem_nxt = trial[VALUE_WIDTH-1:0];
        quo_nxt = {quo_r[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[VALUE_WIDTH-1:0];
        quo_nxt = {quo_r[VALUE_WIDTH-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - DIV_CNT_W'(1);
      done_nxt = (cnt_r == DIV_CNT_W'(1));
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

@@ hdl/rational_arithmetic_unit_core.sv @@
// rational_arithmetic_unit_core: add, subtract, multiply, divide, reduce and compare of fractions
// add, subtract, multiply and divide pass decode, the multiplier steps, combine and final before
// out_strobe; compare strobes from combine, error answers from decode; reduce runs the Euclid
// remainder steps (up to about 46 at 32 bits) and both quotients on the shared divider, then final.
// one item at a time: busy drops with the strobe, so the next start transfer can land on the
// edge that ends the strobe cycle; results cannot be stalled.
// synchronous active-low reset returns the sequencer to idle and clears out_strobe.
// depends on rau_pkg and rau_div
module rational_arithmetic_unit_core import rau_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          in_action,
  input  logic signed [31:0]  in_a_num,
  input  logic signed [31:0]  in_a_den,
  input  logic signed [31:0]  in_b_num,
  input  logic signed [31:0]  in_b_den,
  output logic                out_strobe,
  output logic signed [31:0]  out_res_num,
  output logic [30:0]         out_res_den,
  output logic [1:0]          out_status,
  output logic [1:0]          out_order
);

  localparam int W = VALUE_WIDTH;

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_MUL    = 4'd2;
  localparam logic [3:0] S_COMB   = 4'd3;
  localparam logic [3:0] S_GCD    = 4'd4;
  localparam logic [3:0] S_GWAIT  = 4'd5;
  localparam logic [3:0] S_QNUM   = 4'd6;
  localparam logic [3:0] S_QNWAIT = 4'd7;
  localparam logic [3:0] S_QDEN   = 4'd8;
  localparam logic [3:0] S_QDWAIT = 4'd9;
  localparam logic [3:0] S_FINAL  = 4'd10;

  logic [3:0]        state_r, state_nxt;
  logic [1:0]        step_r, step_nxt;
  logic              strobe_r, strobe_nxt;

  logic [2:0]        act_r, act_nxt;
  logic [W-1:0]      a_num_r, a_num_nxt, a_den_r, a_den_nxt;
  logic [W-1:0]      b_num_r, b_num_nxt, b_den_r, b_den_nxt;
  logic [W-1:0]      an_mag_r, an_mag_nxt, ad_mag_r, ad_mag_nxt;
  logic [W-1:0]      bn_mag_r, bn_mag_nxt, bd_mag_r, bd_mag_nxt;
  logic              an_neg_r, an_neg_nxt, bn_neg_r, bn_neg_nxt;
  logic [PROD_W-1:0] p0_r, p0_nxt, p1_r, p1_nxt, p2_r, p2_nxt;
  logic [W-1:0]      x_r, x_nxt, y_r, y_nxt;
  logic              num_neg_r, num_neg_nxt;
  logic [PROD_W-1:0] num_mag_r, num_mag_nxt;
  logic [PROD_W-1:0] den_r, den_nxt;

  logic signed [31:0] res_num_r, res_num_nxt;
  logic [30:0]        res_den_r, res_den_nxt;
  logic [1:0]         status_r, status_nxt;
  logic [1:0]         order_r, order_nxt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [W-1:0]      mul_a, mul_b;
  logic [PROD_W-1:0] prod;
  logic [PROD_W:0]   d01;
  logic [PROD_W-1:0] d10, sum01;
  logic              ge01, eq01, s0, s1;
  logic              neg_f, ovf;
  logic [PROD_W-1:0] wrapped;
  logic signed [W-1:0] res_w;

  // shared divider for the Euclid remainders and the reduce quotients
  rau_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // operand select for the shared multiplier, one product per cycle
  always_comb begin
    case (step_r)
      2'd0: begin
        mul_a = an_mag_r;
        mul_b = (act_r == ACT_MUL) ? bn_mag_r : bd_mag_r;
      end
      2'd1: begin
        mul_a = bn_mag_r;
        mul_b = ad_mag_r;
      end
      default: begin
        mul_a = ad_mag_r;
        mul_b = (act_r == ACT_DIV) ? bn_mag_r : bd_mag_r;
      end
    endcase
    prod = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // signed-magnitude add and compare of the two cross products
  always_comb begin
    d01   = {1'b0, p0_r} - {1'b0, p1_r};
    d10   = p1_r - p0_r;
    sum01 = p0_r + p1_r;
    ge01  = !d01[PROD_W];
    eq01  = (p0_r == p1_r);
    s0    = an_neg_r;
    s1    = bn_neg_r ^ (act_r == ACT_SUB);
  end

  // range check and wrap of the final result
  always_comb begin
    neg_f   = num_neg_r && (num_mag_r != '0);
    ovf     = (neg_f ? (num_mag_r > HALF) : (num_mag_r > HALF - PROD_W'(1))) ||
              (den_r > HALF - PROD_W'(1));
    wrapped = neg_f ? (~num_mag_r + PROD_W'(1)) : num_mag_r;
    res_w   = wrapped[W-1:0];
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    strobe_nxt  = 1'b0;
    act_nxt     = act_r;
    a_num_nxt   = a_num_r;
    a_den_nxt   = a_den_r;
    b_num_nxt   = b_num_r;
    b_den_nxt   = b_den_r;
    an_mag_nxt  = an_mag_r;
    ad_mag_nxt  = ad_mag_r;
    bn_mag_nxt  = bn_mag_r;
    bd_mag_nxt  = bd_mag_r;
    an_neg_nxt  = an_neg_r;
    bn_neg_nxt  = bn_neg_r;
    p0_nxt      = p0_r;
    p1_nxt      = p1_r;
    p2_nxt      = p2_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    num_neg_nxt = num_neg_r;
    num_mag_nxt = num_mag_r;
    den_nxt     = den_r;
    res_num_nxt = res_num_r;
    res_den_nxt = res_den_r;
    status_nxt  = status_r;
    order_nxt   = order_r;
    div_req.go       = 1'b0;
    div_req.dividend = x_r;
    div_req.divisor  = y_r;

    case (state_r)
      S_IDLE: begin
        // capture the item
        if (start) begin
          act_nxt   = in_action;
          a_num_nxt = in_a_num[W-1:0];
          a_den_nxt = in_a_den[W-1:0];
          b_num_nxt = in_b_num[W-1:0];
          b_den_nxt = in_b_den[W-1:0];
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        // error answers, sign normalization
        res_num_nxt = '0;
        res_den_nxt = '0;
        status_nxt  = ST_OK;
        order_nxt   = ORD_EQ;
        an_mag_nxt  = mag_of(a_num_r);
        ad_mag_nxt  = mag_of(a_den_r);
        bn_mag_nxt  = mag_of(b_num_r);
        bd_mag_nxt  = mag_of(b_den_r);
        an_neg_nxt  = (a_num_r[W-1] ^ a_den_r[W-1]) && (a_num_r != '0);
        bn_neg_nxt  = (b_num_r[W-1] ^ b_den_r[W-1]) && (b_num_r != '0);
        x_nxt       = mag_of(a_num_r);
        y_nxt       = mag_of(a_den_r);
        step_nxt    = 2'd0;
        if (act_r > ACT_CMP) begin
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end else if ((a_den_r == '0) || ((act_r != ACT_RED) && (b_den_r == '0))) begin
          status_nxt = ST_ZDEN;
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end else if ((act_r == ACT_DIV) && (b_num_r == '0)) begin
          status_nxt = ST_DIVZ;
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end else if (act_r == ACT_RED) begin
          state_nxt = S_GCD;
        end else begin
          state_nxt = S_MUL;
        end
      end

      S_MUL: begin
        // three products through one multiplier
        case (step_r)
          2'd0:    p0_nxt = prod;
          2'd1:    p1_nxt = prod;
          default: p2_nxt = prod;
        endcase
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd2) begin
          state_nxt = S_COMB;
        end
      end

      S_COMB: begin
        den_nxt = p2_r;
        case (act_r)
          ACT_ADD, ACT_SUB: begin
            if (s0 == s1) begin
              num_mag_nxt = sum01;
              num_neg_nxt = s0;
            end else if (ge01) begin
              num_mag_nxt = d01[PROD_W-1:0];
              num_neg_nxt = s0;
            end else begin
              num_mag_nxt = d10;
              num_neg_nxt = s1;
            end
            state_nxt = S_FINAL;
          end
          ACT_MUL, ACT_DIV: begin
            num_mag_nxt = p0_r;
            num_neg_nxt = an_neg_r ^ bn_neg_r;
            state_nxt   = S_FINAL;
          end
          default: begin
            // compare of the signed cross products
            if (an_neg_r != bn_neg_r) begin
              order_nxt = an_neg_r ? ORD_LESS : ORD_GRTR;
            end else if (eq01) begin
              order_nxt = ORD_EQ;
            end else if (an_neg_r) begin
              order_nxt = ge01 ? ORD_LESS : ORD_GRTR;
            end else begin
              order_nxt = ge01 ? ORD_GRTR : ORD_LESS;
            end
            strobe_nxt = 1'b1;
            state_nxt  = S_IDLE;
          end
        endcase
      end

      S_GCD: begin
        // Euclid: x, y <- y, x mod y until y is zero
        if (y_r == '0) begin
          state_nxt = S_QNUM;
        end else begin
          div_req.go = 1'b1;
          state_nxt  = S_GWAIT;
        end
      end

      S_GWAIT: begin
        if (div_rsp.done) begin
          x_nxt     = y_r;
          y_nxt     = div_rsp.rem;
          state_nxt = S_GCD;
        end
      end

      S_QNUM: begin
        div_req.go       = 1'b1;
        div_req.dividend = an_mag_r;
        div_req.divisor  = x_r;
        state_nxt        = S_QNWAIT;
      end

      S_QNWAIT: begin
        if (div_rsp.done) begin
          num_mag_nxt = PROD_W'(div_rsp.quo);
          num_neg_nxt = an_neg_r;
          state_nxt   = S_QDEN;
        end
      end

      S_QDEN: begin
        div_req.go       = 1'b1;
        div_req.dividend = ad_mag_r;
        div_req.divisor  = x_r;
        state_nxt        = S_QDWAIT;
      end

      S_QDWAIT: begin
        if (div_rsp.done) begin
          den_nxt   = PROD_W'(div_rsp.quo);
          state_nxt = S_FINAL;
        end
      end

      S_FINAL: begin
        // wrap and flag the result
        res_num_nxt = FIELD_W'(res_w);
        res_den_nxt = DEN_W'(den_r[W-2:0]);
        status_nxt  = ovf ? ST_OVF : ST_OK;
        order_nxt   = ORD_EQ;
        strobe_nxt  = 1'b1;
        state_nxt   = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      step_r   <= 2'd0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      step_r   <= step_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // datapath and result registers
  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    a_num_r   <= a_num_nxt;
    a_den_r   <= a_den_nxt;
    b_num_r   <= b_num_nxt;
    b_den_r   <= b_den_nxt;
    an_mag_r  <= an_mag_nxt;
    ad_mag_r  <= ad_mag_nxt;
    bn_mag_r  <= bn_mag_nxt;
    bd_mag_r  <= bd_mag_nxt;
    an_neg_r  <= an_neg_nxt;
    bn_neg_r  <= bn_neg_nxt;
    p0_r      <= p0_nxt;
    p1_r      <= p1_nxt;
    p2_r      <= p2_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    num_neg_r <= num_neg_nxt;
    num_mag_r <= num_mag_nxt;
    den_r     <= den_nxt;
    res_num_r <= res_num_nxt;
    res_den_r <= res_den_nxt;
    status_r  <= status_nxt;
    order_r   <= order_nxt;
  end

  assign busy        = (state_r != S_IDLE);
  assign out_strobe  = strobe_r;
  assign out_res_num = res_num_r;
  assign out_res_den = res_den_r;
  assign out_status  = status_r;
  assign out_order   = order_r;

endmodule
